[rtl/core/wstq_pkg.sv]
// Package for the work-stealing task queues: sizes, request and status codes,
// and the structs passed between the queue controller and the top level.
// No dependencies.
package wstq_pkg;

  localparam int NUM_WORKERS = 4;
  localparam int QUEUE_DEPTH = 1024;
  localparam int TASK_WIDTH  = 32;

  localparam int WID_W  = $clog2(NUM_WORKERS);
  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int PTR_W  = SLOT_W + 1;
  localparam int ADDR_W = WID_W + SLOT_W;
  localparam int ACT_W  = 3;
  localparam int SUM_W  = ACT_W + 1;

  localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(NUM_WORKERS);

  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_FETCH = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_GIVEN = 2'd2,
    ST_NONE  = 2'd3
  } status_e;

  // Memory access issued by the controller at the accept edge.
  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [ADDR_W-1:0]     addr;
    logic [TASK_WIDTH-1:0] wdata;
  } mem_req_t;

  // Decision for one request, held until the result transfer.
  typedef struct packed {
    status_e          status;
    logic [WID_W-1:0] src;
    logic             stolen;
  } res_t;

endpackage

[rtl/core/work_stealing_task_queues.sv]
// Top level of the work-stealing task queues.
// Uses wstq_pkg, wstq_ctrl and wstq_ram.
//
// Usage:
//  - Request channel (in_valid_i / in_stall_o): one transfer carries
//    req_type_i, worker_id_i and task_handle_i. An add writes the task at
//    the tail of the round-robin queue; a fetch pops the worker's own queue
//    or steals the head of the next non-empty active queue.
//  - Result channel (out_valid_o / out_stall_i): exactly one result per
//    request: status_o, task_out_o, source_queue_o, was_stolen_o.
//  - Config: cfg_we_i writes active_workers (cfg_data_i); only while idle.
//  - Flow: the decision and pointer update happen at the accept edge; the
//    task store (4096 x 32, one port) is read or written at that edge, the
//    decision waits in the pending stage, and the registered read data moves
//    into the output register once it is free. A new request is not taken
//    until the previous one has left the pending stage.
//  - Requests run one at a time, so no two store accesses overlap and no
//    forwarding is needed.
//  - A stalled result holds; the next request is still accepted and waits
//    in the pending stage until the output register frees.
//  - Reset: all queues empty, round-robin target 0, active_workers 4.
//    The task store is not cleared; only written entries are ever read.
module work_stealing_task_queues
  import wstq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  req_type_i,
  input  logic [1:0]            worker_id_i,
  input  logic [TASK_WIDTH-1:0] task_handle_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [TASK_WIDTH-1:0] task_out_o,
  output logic [1:0]            source_queue_o,
  output logic                  was_stolen_o,
  input  logic                  cfg_we_i,
  input  logic [ACT_W-1:0]      cfg_data_i
);

  mem_req_t              mem_req;
  res_t                  res;
  logic [TASK_WIDTH-1:0] rdata;
  logic                  in_accept;
  logic                  out_free;
  logic                  pend_q, pend_d;
  res_t                  pend_res_q;
  logic                  out_valid_q, out_valid_d;
  res_t                  out_res_q;
  logic [TASK_WIDTH-1:0] out_task_q;

  // one request in flight: stall while the pending stage is occupied
  assign in_stall_o = pend_q;
  assign in_accept  = in_valid_i & ~pend_q;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  wstq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .req_type_i   (req_type_i),
    .worker_id_i  (worker_id_i),
    .task_handle_i(task_handle_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .mem_o        (mem_req),
    .res_o        (res)
  );

  wstq_ram #(
    .ADDR_W(ADDR_W),
    .DATA_W(TASK_WIDTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_req.we),
    .re_i   (mem_req.re),
    .addr_i (mem_req.addr),
    .wdata_i(mem_req.wdata),
    .rdata_o(rdata)
  );

  always_comb begin
    pend_d = pend_q;
    if (in_accept) begin
      pend_d = 1'b1;
    end else if (pend_q && out_free) begin
      pend_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pend_q && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pend_res_q <= res;
    end
    if (pend_q && out_free) begin
      out_res_q  <= pend_res_q;
      // store data is held since no read happens while pending
      out_task_q <= (pend_res_q.status == ST_GIVEN) ? rdata : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_res_q.status;
  assign task_out_o     = out_task_q;
  assign source_queue_o = out_res_q.src;
  assign was_stolen_o   = out_res_q.stolen;

endmodule

[rtl/core/wstq_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module wstq_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/wstq_ctrl.sv]
// Queue controller: head/tail pointers, round-robin target, active count,
// and the add / fetch / steal decision. Uses wstq_pkg.
module wstq_ctrl
  import wstq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic                  req_type_i,
  input  logic [WID_W-1:0]      worker_id_i,
  input  logic [TASK_WIDTH-1:0] task_handle_i,
  input  logic                  cfg_we_i,
  input  logic [ACT_W-1:0]      cfg_data_i,
  output mem_req_t              mem_o,
  output res_t                  res_o
);

  logic [ACT_W-1:0] act_q;
  logic [PTR_W-1:0] head_q [NUM_WORKERS];
  logic [PTR_W-1:0] tail_q [NUM_WORKERS];
  logic [WID_W-1:0] tgt_q, tgt_d;

  logic [ACT_W-1:0]  act_eff;
  logic [PTR_W-1:0]  occ     [NUM_WORKERS];
  logic [NUM_WORKERS-1:0] nonempty;
  logic [NUM_WORKERS-1:0] full;
  logic [WID_W-1:0]  cand    [NUM_WORKERS];
  logic [WID_W-1:0]  add_wid;
  logic [WID_W-1:0]  sel_wid;
  logic              is_add;
  logic              do_write;
  logic              do_read;
  logic              steal_hit;
  logic [WID_W-1:0]  steal_wid;
  logic              wid_ok;

  // clamp the active count to 1..NUM_WORKERS
  always_comb begin
    act_eff = act_q;
    if (act_q == '0) begin
      act_eff = ACT_W'(1);
    end else if (act_q > ACT_W'(NUM_WORKERS)) begin
      act_eff = ACT_W'(NUM_WORKERS);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_WORKERS; i++) begin
      occ[i]      = tail_q[i] - head_q[i];
      nonempty[i] = (occ[i] != '0);
      full[i]     = (occ[i] >= PTR_W'(QUEUE_DEPTH));
    end
  end

  // steal candidates: (worker + k) wrapped at the active count
  always_comb begin
    logic [SUM_W-1:0] sum;
    for (int k = 0; k < NUM_WORKERS; k++) begin
      sum = SUM_W'(worker_id_i) + SUM_W'(k);
      if (sum >= SUM_W'(act_eff)) begin
        sum = sum - SUM_W'(act_eff);
      end
      cand[k] = sum[WID_W-1:0];
    end
  end

  // lowest k wins
  always_comb begin
    steal_hit = 1'b0;
    steal_wid = '0;
    for (int k = NUM_WORKERS - 1; k >= 1; k--) begin
      if ((ACT_W'(k) < act_eff) && nonempty[cand[k]]) begin
        steal_hit = 1'b1;
        steal_wid = cand[k];
      end
    end
  end

  assign is_add  = (req_type_i == REQ_ADD);
  assign wid_ok  = (ACT_W'(worker_id_i) < act_eff);
  assign add_wid = (ACT_W'(tgt_q) < act_eff) ? tgt_q : '0;
  assign tgt_d   = ((ACT_W'(add_wid) + ACT_W'(1)) == act_eff) ? '0 : add_wid + WID_W'(1);

  always_comb begin
    res_o.status = ST_NONE;
    res_o.src    = worker_id_i;
    res_o.stolen = 1'b0;
    sel_wid      = worker_id_i;
    do_write     = 1'b0;
    do_read      = 1'b0;
    if (is_add) begin
      res_o.src = add_wid;
      sel_wid   = add_wid;
      if (full[add_wid]) begin
        res_o.status = ST_FULL;
      end else begin
        res_o.status = ST_ADDED;
        do_write     = 1'b1;
      end
    end else if (wid_ok) begin
      if (nonempty[worker_id_i]) begin
        res_o.status = ST_GIVEN;
        do_read      = 1'b1;
      end else if (steal_hit) begin
        res_o.status = ST_GIVEN;
        res_o.src    = steal_wid;
        res_o.stolen = 1'b1;
        sel_wid      = steal_wid;
        do_read      = 1'b1;
      end
    end
  end

  always_comb begin
    mem_o.we    = accept_i & do_write;
    mem_o.re    = accept_i & do_read;
    mem_o.wdata = task_handle_i;
    mem_o.addr  = is_add ? {sel_wid, tail_q[sel_wid][SLOT_W-1:0]}
                         : {sel_wid, head_q[sel_wid][SLOT_W-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= ACT_RESET;
      tgt_q <= '0;
      for (int i = 0; i < NUM_WORKERS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        act_q <= cfg_data_i;
      end
      if (accept_i && is_add) begin
        tgt_q <= tgt_d;
      end
      if (accept_i && do_write) begin
        tail_q[sel_wid] <= tail_q[sel_wid] + PTR_W'(1);
      end
      if (accept_i && do_read) begin
        head_q[sel_wid] <= head_q[sel_wid] + PTR_W'(1);
      end
    end
  end

endmodule

[tb/tb_work_stealing_task_queues.sv]
// Testbench for work_stealing_task_queues: directed table, then random phases
// per active-worker setting, results checked against typed-in replies or a
// local queue model. Depends on wstq_pkg and work_stealing_task_queues RTL.
`timescale 1ns / 1ps

module tb_work_stealing_task_queues;
  import wstq_pkg::*;

  // One expected result transfer.
  typedef struct packed {
    status_e               status;
    logic [TASK_WIDTH-1:0] word;
    logic [1:0]            src;
    logic                  stolen;
  } reply_t;

  typedef enum logic {
    ROW_REQ = 1'b0,
    ROW_CFG = 1'b1
  } row_kind_e;

  // Directed row: either a register write or a request. Where fixed is set the
  // reply is typed in; otherwise the model supplies it.
  typedef struct packed {
    row_kind_e             kind;
    logic [ACT_W-1:0]      act;
    req_e                  req;
    logic [1:0]            wid;
    logic [TASK_WIDTH-1:0] handle;
    logic                  fixed;
    reply_t                want;
  } plan_row_t;

  localparam reply_t NO_REPLY = '{ST_ADDED, 32'h0, 2'd0, 1'b0};

  localparam int PLAN_LEN = 26;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // fresh out of reset: nothing to give, own id reported
    '{ROW_REQ, 3'd0, REQ_FETCH, 2'd0, 32'hFFFF_FFFF, 1'b1, '{ST_NONE, 32'h0, 2'd0, 1'b0}},
    '{ROW_REQ, 3'd0, REQ_FETCH, 2'd3, 32'h0000_0000, 1'b1, '{ST_NONE, 32'h0, 2'd3, 1'b0}},
    // round robin over all four queues, worker id ignored on add
    '{ROW_REQ, 3'd0, REQ_ADD, 2'd3, 32'hFFFF_FFFF, 1'b1, '{ST_ADDED, 32'h0, 2'd0, 1'b0}},
    '{ROW_REQ, 3'd0, REQ_ADD, 2'd2, 32'h0000_0000, 1'b1, '{ST_ADDED, 32'h0, 2'd1, 1'b0}},
    '{ROW_REQ, 3'd0, REQ_ADD, 2'd1, 32'hA5A5_5A5A, 1'b1, '{ST_ADDED, 32'h0, 2'd2, 1'b0}},
    '{ROW_REQ, 3'd0, REQ_ADD, 2'd0, 32'h1234_5678, 1'b1, '{ST_ADDED, 32'h0, 2'd3, 1'b0}},
    // own pop, then a steal from the next queue, then own pop of queue 3
    '{ROW_REQ, 3'd0, REQ_FETCH, 2'd0, 32'h0, 1'b1, '{ST_GIVEN, 32'hFFFF_FFFF, 2'd0, 1'b0}},
    '{ROW_REQ, 3'd0, REQ_FETCH, 2'd0, 32'h0, 1'b1, '{ST_GIVEN, 32'h0000_0000, 2'd1, 1'b1}},
    '{ROW_REQ, 3'd0, REQ_FETCH, 2'd3, 32'h0, 1'b1, '{ST_GIVEN, 32'h1234_5678, 2'd3, 1'b0}},
    '{ROW_REQ, 3'd0, REQ_ADD, 2'd0, 32'hDEAD_BEEF, 1'b1, '{ST_ADDED, 32'h0, 2'd0, 1'b0}},
    // zero active workers acts as one; target 1 is now out of range
    '{ROW_CFG, 3'd0, REQ_ADD, 2'd0, 32'h0, 1'b0, NO_REPLY},
    '{ROW_REQ, 3'd0, REQ_FETCH, 2'd2, 32'h0, 1'b1, '{ST_NONE, 32'h0, 2'd2, 1'b0}},
    '{ROW_REQ, 3'd0, REQ_ADD, 2'd1, 32'h0F0F_0F0F, 1'b1, '{ST_ADDED, 32'h0, 2'd0, 1'b0}},
    '{ROW_REQ, 3'd0, REQ_FETCH, 2'd0, 32'h0, 1'b1, '{ST_GIVEN, 32'hDEAD_BEEF, 2'd0, 1'b0}},
    '{ROW_REQ, 3'd0, REQ_FETCH, 2'd0, 32'h0, 1'b1, '{ST_GIVEN, 32'h0F0F_0F0F, 2'd0, 1'b0}},
    // queue 2 still holds a task but is out of reach with one worker
    '{ROW_REQ, 3'd0, REQ_FETCH, 2'd0, 32'h0, 1'b1, '{ST_NONE, 32'h0, 2'd0, 1'b0}},
    // count above the worker number clamps to four; the parked task is back
    '{ROW_CFG, 3'd7, REQ_ADD, 2'd0, 32'h0, 1'b0, NO_REPLY},
    '{ROW_REQ, 3'd0, REQ_FETCH, 2'd1, 32'h0, 1'b1, '{ST_GIVEN, 32'hA5A5_5A5A, 2'd2, 1'b1}},
    '{ROW_REQ, 3'd0, REQ_FETCH, 2'd1, 32'h0, 1'b1, '{ST_NONE, 32'h0, 2'd1, 1'b0}},
    // two workers: wrap of the round robin and of the steal scan
    '{ROW_CFG, 3'd2, REQ_ADD, 2'd0, 32'h0, 1'b0, NO_REPLY},
    '{ROW_REQ, 3'd0, REQ_ADD, 2'd0, 32'h8000_0001, 1'b0, NO_REPLY},
    '{ROW_REQ, 3'd0, REQ_ADD, 2'd3, 32'h7FFF_FFFE, 1'b0, NO_REPLY},
    '{ROW_REQ, 3'd0, REQ_ADD, 2'd1, 32'h5555_AAAA, 1'b0, NO_REPLY},
    '{ROW_REQ, 3'd0, REQ_FETCH, 2'd1, 32'hFFFF_FFFF, 1'b0, NO_REPLY},
    '{ROW_REQ, 3'd0, REQ_FETCH, 2'd1, 32'h0, 1'b0, NO_REPLY},
    // inactive worker asks
    '{ROW_REQ, 3'd0, REQ_FETCH, 2'd3, 32'h0, 1'b0, NO_REPLY}
  };

  // Random phases. Phase 2 is add-only with one worker so queue 0 runs full
  // and rejects a few adds; the phases after it steal from that backlog.
  localparam int NUM_PHASES = 7;
  localparam logic [ACT_W-1:0] PH_ACT [NUM_PHASES] = '{3'd4, 3'd3, 3'd1, 3'd5, 3'd2, 3'd0, 3'd6};
  localparam int PH_ITEMS [NUM_PHASES]   = '{16, 10, 1026, 10, 6, 4, 8};
  localparam int PH_ADD_PCT [NUM_PHASES] = '{55, 50, 100, 40, 50, 50, 45};
  localparam bit PH_BURST [NUM_PHASES]   = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  req_type_i;
  logic [1:0]            worker_id_i;
  logic [TASK_WIDTH-1:0] task_handle_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [1:0]            status_o;
  logic [TASK_WIDTH-1:0] task_out_o;
  logic [1:0]            source_queue_o;
  logic                  was_stolen_o;
  logic                  cfg_we_i;
  logic [ACT_W-1:0]      cfg_data_i;

  // Queue model state.
  logic [ACT_W-1:0]      act_cfg;
  int                    rr_target;
  logic [PTR_W-1:0]      q_head [NUM_WORKERS];
  logic [PTR_W-1:0]      q_tail [NUM_WORKERS];
  logic [TASK_WIDTH-1:0] task_mem [NUM_WORKERS*QUEUE_DEPTH];

  reply_t pending_replies [$];
  reply_t head_reply;
  int     n_fail = 0;
  int     n_replies = 0;
  bit     no_idle = 1'b0;   // set during burst phases: neither side idles

  always #6 clk_i = ~clk_i;

  work_stealing_task_queues dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .worker_id_i    (worker_id_i),
    .task_handle_i  (task_handle_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .task_out_o     (task_out_o),
    .source_queue_o (source_queue_o),
    .was_stolen_o   (was_stolen_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Pointers run modulo 2*QUEUE_DEPTH, so the 11-bit difference is the fill.
  function automatic logic [PTR_W-1:0] q_fill(int q);
    return q_tail[q] - q_head[q];
  endfunction

  // Applies one request to the model queues and returns the result it causes.
  function automatic reply_t resolve_request(req_e req, logic [1:0] wid,
                                             logic [TASK_WIDTH-1:0] handle);
    reply_t r;
    int     act;
    int     q;
    bit     found;
    act = (act_cfg == 0) ? 1 : ((act_cfg > NUM_WORKERS) ? NUM_WORKERS : int'(act_cfg));
    r.status = ST_NONE;
    r.word   = '0;
    r.src    = wid;
    r.stolen = 1'b0;
    found    = 1'b0;
    if (req == REQ_ADD) begin
      // stale target after a register write falls back to queue 0
      q = (rr_target < act) ? rr_target : 0;
      r.src = 2'(q);
      if (q_fill(q) >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        task_mem[q*QUEUE_DEPTH + int'(q_tail[q][SLOT_W-1:0])] = handle;
        q_tail[q] = q_tail[q] + 1'b1;
        r.status = ST_ADDED;
      end
      rr_target = (q + 1 == act) ? 0 : q + 1;
    end else if (int'(wid) < act) begin
      // k = 0 is the worker's own queue; anything later is a steal
      for (int k = 0; k < act; k++) begin
        q = (int'(wid) + k) % act;
        if (!found && q_fill(q) != 0) begin
          found    = 1'b1;
          r.status = ST_GIVEN;
          r.word   = task_mem[q*QUEUE_DEPTH + int'(q_head[q][SLOT_W-1:0])];
          r.src    = 2'(q);
          r.stolen = (k != 0);
          q_head[q] = q_head[q] + 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one request from a falling edge and returns at a falling edge after
  // the transfer. Valid stays high into the next request when there is no gap.
  task automatic push_req(input req_e req, input logic [1:0] wid,
                          input logic [TASK_WIDTH-1:0] handle,
                          input logic fixed, input reply_t want);
    reply_t got;
    int     gap;
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    worker_id_i   <= wid;
    task_handle_i <= handle;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    got = resolve_request(req, wid, handle);
    pending_replies = {pending_replies, (fixed ? want : got)};
    @(negedge clk_i);
    gap = no_idle ? 0 : idle_cycles();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Register write only once the block is drained.
  task automatic write_active(input logic [ACT_W-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    act_cfg = value;
  endtask

  // Result side: random stalls, plus one long hold-off early in the random
  // part while the sender keeps offering, so the request side backs up.
  initial begin : result_sink
    int gap;
    bit held;
    held        = 1'b0;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!held && n_replies >= 60) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (80) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        gap = no_idle ? 0 : idle_cycles();
        if (gap != 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Result check at every transfer against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_replies.size() == 0) begin
        $error("result transfer with nothing expected: status %0d", status_o);
        n_fail = n_fail + 1;
      end else begin
        head_reply = pending_replies.pop_front();
        if (status_o !== head_reply.status) begin
          $error("status: expected %0d, got %0d", head_reply.status, status_o);
          n_fail = n_fail + 1;
        end
        if (task_out_o !== head_reply.word) begin
          $error("task_out: expected %h, got %h", head_reply.word, task_out_o);
          n_fail = n_fail + 1;
        end
        if (source_queue_o !== head_reply.src) begin
          $error("source_queue: expected %0d, got %0d", head_reply.src, source_queue_o);
          n_fail = n_fail + 1;
        end
        if (was_stolen_o !== head_reply.stolen) begin
          $error("was_stolen: expected %0d, got %0d", head_reply.stolen, was_stolen_o);
          n_fail = n_fail + 1;
        end
        n_replies = n_replies + 1;
      end
    end
  end

  initial begin : stimulus
    req_e req;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    req_type_i    = REQ_ADD;
    worker_id_i   = 2'd0;
    task_handle_i = '0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = ACT_RESET;
    act_cfg       = ACT_RESET;
    rr_target     = 0;
    for (int q = 0; q < NUM_WORKERS; q++) begin
      q_head[q] = '0;
      q_tail[q] = '0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        write_active(PLAN[i].act);
      end else begin
        push_req(PLAN[i].req, PLAN[i].wid, PLAN[i].handle, PLAN[i].fixed, PLAN[i].want);
      end
    end

    // random phases, one register setting each
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_active(PH_ACT[p]);
      no_idle = PH_BURST[p];
      for (int i = 0; i < PH_ITEMS[p]; i++) begin
        req = ($urandom_range(0, 99) < PH_ADD_PCT[p]) ? REQ_ADD : REQ_FETCH;
        push_req(req, 2'($urandom_range(0, 3)), $urandom(), 1'b0, NO_REPLY);
      end
    end

    in_valid_i <= 1'b0;
    no_idle = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hang guard: several times the slowest legal run.
  initial begin : watchdog
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
